// ===== sv/vmrp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Video memory register port package
// Shared constants, register offsets, read source codes and the structs that
// pass between the register decode, the stores and the result pipeline.
// ----------------------------------------------------------------------------
package vmrp_pkg;

  // Default size of the video word store.
  localparam int VIDEO_WORDS_DEF = 32768;

  // Fixed store geometry of the sprite attribute and palette stores, and the video pointer width.
  localparam int SPR_PAIRS    = 256;
  localparam int SPR_HIGH     = 32;
  localparam int PAL_DEPTH    = 256;
  localparam int COLOR_W      = 15;
  localparam int VPTR_W       = 15;

  // Access kinds.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Write offsets.
  localparam logic [5:0] OFF_DISPLAY   = 6'h00;
  localparam logic [5:0] OFF_SPR_ADDRL = 6'h02;
  localparam logic [5:0] OFF_SPR_ADDRH = 6'h03;
  localparam logic [5:0] OFF_SPR_DATA  = 6'h04;
  localparam logic [5:0] OFF_VID_MODE  = 6'h15;
  localparam logic [5:0] OFF_VID_ADDRL = 6'h16;
  localparam logic [5:0] OFF_VID_ADDRH = 6'h17;
  localparam logic [5:0] OFF_VID_DATAL = 6'h18;
  localparam logic [5:0] OFF_VID_DATAH = 6'h19;
  localparam logic [5:0] OFF_PAL_ADDR  = 6'h21;
  localparam logic [5:0] OFF_PAL_DATA  = 6'h22;
  localparam logic [5:0] OFF_FIXED_COL = 6'h32;

  // Read offsets.
  localparam logic [5:0] OFF_SPR_READ  = 6'h38;
  localparam logic [5:0] OFF_VID_READL = 6'h39;
  localparam logic [5:0] OFF_VID_READH = 6'h3a;
  localparam logic [5:0] OFF_PAL_READ  = 6'h3b;
  localparam logic [5:0] OFF_STATUS    = 6'h3e;

  // Source of the returned byte.
  localparam logic [2:0] SEL_BYTE     = 3'd0;
  localparam logic [2:0] SEL_VID_LO   = 3'd1;
  localparam logic [2:0] SEL_VID_HI   = 3'd2;
  localparam logic [2:0] SEL_SPR_EVEN = 3'd3;
  localparam logic [2:0] SEL_SPR_ODD  = 3'd4;
  localparam logic [2:0] SEL_SPR_HIGH = 3'd5;
  localparam logic [2:0] SEL_PAL_LO   = 3'd6;
  localparam logic [2:0] SEL_PAL_HI   = 3'd7;

  // Store requests issued for one accepted word.
  typedef struct packed {
    logic               vid_re;
    logic               vid_lo_we;
    logic               vid_hi_we;
    logic [7:0]         vid_wdata;
    logic               spr_re;
    logic               spr_pair_we;
    logic               spr_high_we;
    logic [7:0]         spr_latch;
    logic [7:0]         spr_wdata;
    logic [9:0]         spr_ptr;
    logic               pal_re;
    logic               pal_we;
    logic [7:0]         pal_addr;
    logic [COLOR_W-1:0] pal_wdata;
  } mem_req_t;

  // What the result stage needs to build the output word.
  typedef struct packed {
    logic [2:0]         sel;
    logic [7:0]         byte_val;
    logic               blank;
    logic [3:0]         bright;
    logic [COLOR_W-1:0] fixed;
    logic               rotate;
  } res_info_t;

  // Registered read data of all stores.
  typedef struct packed {
    logic [7:0]         vid_lo;
    logic [7:0]         vid_hi;
    logic [7:0]         spr_even;
    logic [7:0]         spr_odd;
    logic [7:0]         spr_high;
    logic [COLOR_W-1:0] pal;
  } rd_data_t;

endpackage
`default_nettype wire

// ===== sv/video_memory_register_port_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Video memory register port
// Each input word is one CPU read or write at a video register offset (0 to
// 63). Writes update the video word store, the sprite attribute store, the
// palette store, their pointers and latches, and the display registers.
// Reads return store data, a status byte or the open bus value.
//
// Both channels use valid/stall; a word moves when valid is high and stall
// is low. Every accepted word yields exactly one result word, in order.
// The decode, the pointer update and the store read all happen at the
// accepting edge; the word then waits in the in-flight register until the
// result register frees, and out_valid rises when the result register
// loads it. Throughput is one word per cycle while results are taken.
// When the receiver stalls, the result register holds and one more
// word may still enter the pipeline before in_stall rises.
// Reset (rst_n low, synchronous) clears all pointers, latches and display
// registers and empties the pipeline. The stores are not cleared and need
// no clearing pass; they return defined data once written.
// ----------------------------------------------------------------------------
module video_memory_register_port_core #(
  parameter int VIDEO_WORDS = vmrp_pkg::VIDEO_WORDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_opcode,
  input  wire logic [5:0]  in_reg_offset,
  input  wire logic [7:0]  in_write_data,
  input  wire logic [7:0]  in_bus_latch,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_read_data,
  output logic             out_blank_forced,
  output logic [3:0]       out_screen_brightness,
  output logic [14:0]      out_fixed_color_value,
  output logic             out_sprite_priority_rotate
);
  import vmrp_pkg::*;

  localparam int VA_W = $clog2(VIDEO_WORDS);

  logic            accept;
  mem_req_t        req;
  res_info_t       info;
  rd_data_t        rd;
  logic [VA_W-1:0] vid_addr;

  // Register decode and pointer state.
  vmrp_ctrl #(
    .VIDEO_WORDS (VIDEO_WORDS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .in_opcode     (in_opcode),
    .in_reg_offset (in_reg_offset),
    .in_write_data (in_write_data),
    .in_bus_latch  (in_bus_latch),
    .req           (req),
    .vid_addr      (vid_addr),
    .info          (info)
  );

  // Video word store, split into byte lanes so each byte writes alone.
  vmrp_ram #(
    .WIDTH (8),
    .DEPTH (VIDEO_WORDS)
  ) u_vid_lo (
    .clk   (clk),
    .we    (req.vid_lo_we),
    .waddr (vid_addr),
    .wdata (req.vid_wdata),
    .re    (req.vid_re),
    .raddr (vid_addr),
    .rdata (rd.vid_lo)
  );

  vmrp_ram #(
    .WIDTH (8),
    .DEPTH (VIDEO_WORDS)
  ) u_vid_hi (
    .clk   (clk),
    .we    (req.vid_hi_we),
    .waddr (vid_addr),
    .wdata (req.vid_wdata),
    .re    (req.vid_re),
    .raddr (vid_addr),
    .rdata (rd.vid_hi)
  );

  // Sprite low table as even and odd banks, so both bytes of a pair store together.
  vmrp_ram #(
    .WIDTH (8),
    .DEPTH (SPR_PAIRS)
  ) u_spr_even (
    .clk   (clk),
    .we    (req.spr_pair_we),
    .waddr (req.spr_ptr[8:1]),
    .wdata (req.spr_latch),
    .re    (req.spr_re),
    .raddr (req.spr_ptr[8:1]),
    .rdata (rd.spr_even)
  );

  vmrp_ram #(
    .WIDTH (8),
    .DEPTH (SPR_PAIRS)
  ) u_spr_odd (
    .clk   (clk),
    .we    (req.spr_pair_we),
    .waddr (req.spr_ptr[8:1]),
    .wdata (req.spr_wdata),
    .re    (req.spr_re),
    .raddr (req.spr_ptr[8:1]),
    .rdata (rd.spr_odd)
  );

  // Sprite high table.
  vmrp_ram #(
    .WIDTH (8),
    .DEPTH (SPR_HIGH)
  ) u_spr_high (
    .clk   (clk),
    .we    (req.spr_high_we),
    .waddr (req.spr_ptr[4:0]),
    .wdata (req.spr_wdata),
    .re    (req.spr_re),
    .raddr (req.spr_ptr[4:0]),
    .rdata (rd.spr_high)
  );

  // Palette store.
  vmrp_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PAL_DEPTH)
  ) u_pal (
    .clk   (clk),
    .we    (req.pal_we),
    .waddr (req.pal_addr),
    .wdata (req.pal_wdata),
    .re    (req.pal_re),
    .raddr (req.pal_addr),
    .rdata (rd.pal)
  );

  // Result selection, result register and handshake.
  vmrp_pipe u_pipe (
    .clk                        (clk),
    .rst_n                      (rst_n),
    .in_valid                   (in_valid),
    .in_stall                   (in_stall),
    .accept                     (accept),
    .info                       (info),
    .rd                         (rd),
    .out_valid                  (out_valid),
    .out_stall                  (out_stall),
    .out_read_data              (out_read_data),
    .out_blank_forced           (out_blank_forced),
    .out_screen_brightness      (out_screen_brightness),
    .out_fixed_color_value      (out_fixed_color_value),
    .out_sprite_priority_rotate (out_sprite_priority_rotate)
  );

endmodule
`default_nettype wire

// ===== sv/vmrp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module vmrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds until the next enabled read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== sv/vmrp_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Video memory register port decode
// Holds the pointers, latches and display registers, decodes each accepted
// word and issues the matching store reads and writes.
// ----------------------------------------------------------------------------
module vmrp_ctrl #(
  parameter int VIDEO_WORDS = vmrp_pkg::VIDEO_WORDS_DEF,
  localparam int VA_W = $clog2(VIDEO_WORDS)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire logic                in_opcode,
  input  wire logic [5:0]          in_reg_offset,
  input  wire logic [7:0]          in_write_data,
  input  wire logic [7:0]          in_bus_latch,
  output vmrp_pkg::mem_req_t       req,
  output logic      [VA_W-1:0]     vid_addr,
  output vmrp_pkg::res_info_t      info
);
  import vmrp_pkg::*;

  logic [VPTR_W-1:0]  vwp_r, vwp_nxt;
  logic [1:0]         vstep_r, vstep_nxt;
  logic [1:0]         vremap_r, vremap_nxt;
  logic               vafter_r, vafter_nxt;
  logic [8:0]         swp_r, swp_nxt;
  logic [9:0]         sbp_r, sbp_nxt;
  logic [7:0]         slatch_r, slatch_nxt;
  logic [7:0]         pptr_r, pptr_nxt;
  logic               pwph_r, pwph_nxt;
  logic [7:0]         platch_r, platch_nxt;
  logic               prph_r, prph_nxt;
  logic               blank_r, blank_nxt;
  logic [3:0]         bright_r, bright_nxt;
  logic [COLOR_W-1:0] fixed_r, fixed_nxt;
  logic               rotate_r, rotate_nxt;

  logic [VPTR_W-1:0]  vid_remap;
  logic [VPTR_W-1:0]  vid_step;
  logic [VPTR_W-1:0]  vwp_adv;
  logic               is_wr;

  // Address remap of the video word pointer.
  always_comb begin
    case (vremap_r)
      2'd1:    vid_remap = {vwp_r[14:8], vwp_r[4:0], vwp_r[7:5]};
      2'd2:    vid_remap = {vwp_r[14:9], vwp_r[5:0], vwp_r[8:6]};
      2'd3:    vid_remap = {vwp_r[14:10], vwp_r[6:0], vwp_r[9:7]};
      default: vid_remap = vwp_r;
    endcase
  end

  assign vid_addr = vid_remap[VA_W-1:0];

  // Pointer step after a video data access.
  always_comb begin
    case (vstep_r)
      2'd0:    vid_step = VPTR_W'(1);
      2'd1:    vid_step = VPTR_W'(32);
      default: vid_step = VPTR_W'(128);
    endcase
  end

  assign vwp_adv = vwp_r + vid_step;
  assign is_wr   = (in_opcode == OP_WRITE);

  // Decode of one accepted word.
  always_comb begin
    vwp_nxt    = vwp_r;
    vstep_nxt  = vstep_r;
    vremap_nxt = vremap_r;
    vafter_nxt = vafter_r;
    swp_nxt    = swp_r;
    sbp_nxt    = sbp_r;
    slatch_nxt = slatch_r;
    pptr_nxt   = pptr_r;
    pwph_nxt   = pwph_r;
    platch_nxt = platch_r;
    prph_nxt   = prph_r;
    blank_nxt  = blank_r;
    bright_nxt = bright_r;
    fixed_nxt  = fixed_r;
    rotate_nxt = rotate_r;

    req             = '0;
    req.vid_wdata   = in_write_data;
    req.spr_latch   = slatch_r;
    req.spr_wdata   = in_write_data;
    req.spr_ptr     = sbp_r;
    req.pal_addr    = pptr_r;
    req.pal_wdata   = {in_write_data[6:0], platch_r};

    info.sel      = SEL_BYTE;
    info.byte_val = is_wr ? 8'h00 : in_bus_latch;

    if (accept) begin
      if (is_wr) begin
        case (in_reg_offset)
          OFF_DISPLAY: begin
            bright_nxt = in_write_data[3:0];
            blank_nxt  = in_write_data[7];
          end
          OFF_SPR_ADDRL: begin
            swp_nxt = {swp_r[8], in_write_data};
            sbp_nxt = {swp_r[8], in_write_data, 1'b0};
          end
          OFF_SPR_ADDRH: begin
            swp_nxt    = {in_write_data[0], swp_r[7:0]};
            sbp_nxt    = {in_write_data[0], swp_r[7:0], 1'b0};
            rotate_nxt = in_write_data[7];
          end
          OFF_SPR_DATA: begin
            if (!sbp_r[9]) begin
              // Low table: the even byte waits in the latch for its pair.
              if (sbp_r[0]) begin
                req.spr_pair_we = 1'b1;
              end else begin
                slatch_nxt = in_write_data;
              end
            end else begin
              // High table: stored at once.
              if (!sbp_r[0]) begin
                slatch_nxt = in_write_data;
              end
              req.spr_high_we = 1'b1;
            end
            sbp_nxt = sbp_r + 10'd1;
          end
          OFF_VID_MODE: begin
            vstep_nxt  = in_write_data[1:0];
            vremap_nxt = in_write_data[3:2];
            vafter_nxt = in_write_data[7];
          end
          OFF_VID_ADDRL: begin
            vwp_nxt = {vwp_r[14:8], in_write_data};
          end
          OFF_VID_ADDRH: begin
            vwp_nxt = {in_write_data[6:0], vwp_r[7:0]};
          end
          OFF_VID_DATAL: begin
            req.vid_lo_we = 1'b1;
            if (!vafter_r) begin
              vwp_nxt = vwp_adv;
            end
          end
          OFF_VID_DATAH: begin
            req.vid_hi_we = 1'b1;
            if (vafter_r) begin
              vwp_nxt = vwp_adv;
            end
          end
          OFF_PAL_ADDR: begin
            pptr_nxt = in_write_data;
            pwph_nxt = 1'b0;
            prph_nxt = 1'b0;
          end
          OFF_PAL_DATA: begin
            if (!pwph_r) begin
              platch_nxt = in_write_data;
              pwph_nxt   = 1'b1;
            end else begin
              req.pal_we = 1'b1;
              pptr_nxt   = pptr_r + 8'd1;
              pwph_nxt   = 1'b0;
            end
          end
          OFF_FIXED_COL: begin
            if (in_write_data[5]) begin
              fixed_nxt[4:0] = in_write_data[4:0];
            end
            if (in_write_data[6]) begin
              fixed_nxt[9:5] = in_write_data[4:0];
            end
            if (in_write_data[7]) begin
              fixed_nxt[14:10] = in_write_data[4:0];
            end
          end
          default: begin
          end
        endcase
      end else begin
        case (in_reg_offset)
          OFF_SPR_READ: begin
            req.spr_re = 1'b1;
            if (sbp_r[9]) begin
              info.sel = SEL_SPR_HIGH;
            end else if (sbp_r[0]) begin
              info.sel = SEL_SPR_ODD;
            end else begin
              info.sel = SEL_SPR_EVEN;
            end
            sbp_nxt = sbp_r + 10'd1;
          end
          OFF_VID_READL: begin
            req.vid_re = 1'b1;
            info.sel   = SEL_VID_LO;
            if (!vafter_r) begin
              vwp_nxt = vwp_adv;
            end
          end
          OFF_VID_READH: begin
            req.vid_re = 1'b1;
            info.sel   = SEL_VID_HI;
            if (vafter_r) begin
              vwp_nxt = vwp_adv;
            end
          end
          OFF_PAL_READ: begin
            req.pal_re = 1'b1;
            if (!prph_r) begin
              info.sel = SEL_PAL_LO;
              prph_nxt = 1'b1;
            end else begin
              // Bit 7 of the high byte comes from open bus.
              info.sel = SEL_PAL_HI;
              pptr_nxt = pptr_r + 8'd1;
              prph_nxt = 1'b0;
            end
          end
          OFF_STATUS: begin
            info.byte_val = {3'b000, in_bus_latch[4], 4'b0001};
          end
          default: begin
          end
        endcase
      end
    end

    // Display state after the access.
    info.blank  = blank_nxt;
    info.bright = bright_nxt;
    info.fixed  = fixed_nxt;
    info.rotate = rotate_nxt;
  end

  // Architectural registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vwp_r    <= '0;
      vstep_r  <= '0;
      vremap_r <= '0;
      vafter_r <= 1'b0;
      swp_r    <= '0;
      sbp_r    <= '0;
      slatch_r <= '0;
      pptr_r   <= '0;
      pwph_r   <= 1'b0;
      platch_r <= '0;
      prph_r   <= 1'b0;
      blank_r  <= 1'b0;
      bright_r <= '0;
      fixed_r  <= '0;
      rotate_r <= 1'b0;
    end else begin
      vwp_r    <= vwp_nxt;
      vstep_r  <= vstep_nxt;
      vremap_r <= vremap_nxt;
      vafter_r <= vafter_nxt;
      swp_r    <= swp_nxt;
      sbp_r    <= sbp_nxt;
      slatch_r <= slatch_nxt;
      pptr_r   <= pptr_nxt;
      pwph_r   <= pwph_nxt;
      platch_r <= platch_nxt;
      prph_r   <= prph_nxt;
      blank_r  <= blank_nxt;
      bright_r <= bright_nxt;
      fixed_r  <= fixed_nxt;
      rotate_r <= rotate_nxt;
    end
  end

`ifndef SYNTHESIS
  // The palette write phase only opens on a palette data write.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(pwph_r) |-> $past(accept && in_opcode == OP_WRITE &&
                            in_reg_offset == OFF_PAL_DATA))
    else $error("palette write phase set without a palette data write");

  // Pointers move only when a word is accepted.
  assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> ($stable(sbp_r) && $stable(vwp_r) && $stable(pptr_r)))
    else $error("store pointer changed without an accepted word");
`endif

endmodule
`default_nettype wire

// ===== sv/vmrp_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Video memory register port result pipeline
// Holds the word in flight while the store reads complete, selects the
// returned byte and drives the result register and the handshake.
// ----------------------------------------------------------------------------
module vmrp_pipe (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     accept,
  input  wire vmrp_pkg::res_info_t info,
  input  wire vmrp_pkg::rd_data_t  rd,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic      [7:0]          out_read_data,
  output logic                     out_blank_forced,
  output logic      [3:0]          out_screen_brightness,
  output logic      [14:0]         out_fixed_color_value,
  output logic                     out_sprite_priority_rotate
);
  import vmrp_pkg::*;

  logic      s1_valid_r, s1_valid_nxt;
  res_info_t s1_info_r;
  logic      out_valid_r, out_valid_nxt;
  logic [7:0]         out_rdata_r;
  logic               out_blank_r;
  logic [3:0]         out_bright_r;
  logic [COLOR_W-1:0] out_fixed_r;
  logic               out_rotate_r;
  logic               move;
  logic [7:0]         rdata_sel;

  // Handshake: the word in flight moves on when the result register frees.
  assign move          = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall      = s1_valid_r && !move;
  assign accept        = in_valid && !in_stall;
  assign s1_valid_nxt  = accept || (s1_valid_r && !move);
  assign out_valid_nxt = move || (out_valid_r && out_stall);

  // Returned byte selection.
  always_comb begin
    case (s1_info_r.sel)
      SEL_BYTE:     rdata_sel = s1_info_r.byte_val;
      SEL_VID_LO:   rdata_sel = rd.vid_lo;
      SEL_VID_HI:   rdata_sel = rd.vid_hi;
      SEL_SPR_EVEN: rdata_sel = rd.spr_even;
      SEL_SPR_ODD:  rdata_sel = rd.spr_odd;
      SEL_SPR_HIGH: rdata_sel = rd.spr_high;
      SEL_PAL_LO:   rdata_sel = rd.pal[7:0];
      SEL_PAL_HI:   rdata_sel = {s1_info_r.byte_val[7], rd.pal[14:8]};
      default:      rdata_sel = s1_info_r.byte_val;
    endcase
  end

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload of the word in flight and of the result register.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info_r <= info;
    end
    if (move) begin
      out_rdata_r  <= rdata_sel;
      out_blank_r  <= s1_info_r.blank;
      out_bright_r <= s1_info_r.bright;
      out_fixed_r  <= s1_info_r.fixed;
      out_rotate_r <= s1_info_r.rotate;
    end
  end

  assign out_valid                  = out_valid_r;
  assign out_read_data              = out_rdata_r;
  assign out_blank_forced           = out_blank_r;
  assign out_screen_brightness      = out_bright_r;
  assign out_fixed_color_value      = out_fixed_r;
  assign out_sprite_priority_rotate = out_rotate_r;

`ifndef SYNTHESIS
  // An accepted word is always in flight on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted word lost");

  // A blocked word in flight keeps its contents.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |=> (s1_valid_r && $stable(s1_info_r)))
    else $error("word in flight changed while blocked");

  // A word that moves on reaches the result register.
  assert property (@(posedge clk) disable iff (!rst_n)
    move |=> out_valid_r)
    else $error("moved word did not reach the result register");
`endif

endmodule
`default_nettype wire
